// ===== rtl/wcpd_pkg.sv =====
package wcpd_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned CNT_W   = 20;
   localparam int unsigned BW_W    = 24;
   localparam int unsigned OFS_W   = 48;
   localparam int unsigned RB_W    = 36;
   localparam int unsigned CS_W    = 31;
   localparam int unsigned RATIO_W = 16;
   localparam int unsigned SCORE_W = 48;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned PI_W    = 3;

   // Function codes of an input transaction.
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CAND  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_CHUNK    = 3'd0;
   localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd1;
   localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_PATH  = 3'd4;
   localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd5;
   localparam logic [STAT_W-1:0] ST_STARTED  = 3'd6;

   // Transfer modes.
   localparam logic [1:0] MODE_POOL   = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_RELAY  = 2'd2;
   localparam logic [1:0] MODE_ALIAS  = 2'd3;

   // Register indexes on the control port.
   localparam logic [2:0] REG_CHUNK_SIZE  = 3'd0;
   localparam logic [2:0] REG_MODE        = 3'd1;
   localparam logic [2:0] REG_MIN_CHUNKS  = 3'd2;
   localparam logic [2:0] REG_BW_FLOOR    = 3'd3;
   localparam logic [2:0] REG_RATIO_FLOOR = 3'd4;
   localparam logic [2:0] REG_DIR_D2H     = 3'd5;

   // One classified work item between the front and the back.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CNT_W-1:0]  chunk_count;
      logic              is_direct;
      logic              p2p_ok;
      logic [BW_W-1:0]   bw;
      logic [OFS_W-1:0]  src;
      logic [OFS_W-1:0]  dst;
      logic [RB_W-1:0]   range_bytes;
   } item_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [CS_W-1:0]    chunk_size;
      logic [1:0]         mode;
      logic [CNT_W-1:0]   min_chunks;
      logic [BW_W-1:0]    bw_floor;
      logic [RATIO_W-1:0] ratio_floor;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PI_W-1:0]   path_index;
      logic [OFS_W-1:0]  src;
      logic [OFS_W-1:0]  dst;
      logic [CS_W-1:0]   len;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/wcpd_queue.sv =====
module wcpd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wcpd_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output wcpd_pkg::item_type pop_data
);
   import wcpd_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff + PTR_W'(do_push);
      rd_in  = rd_ff + PTR_W'(do_pop);
      cnt_in = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage for queued items.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/wcpd_front.sv =====
module wcpd_front (
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_func,
   input  logic [19:0]                 req_plan_chunk_count,
   input  logic                        req_cand_is_direct,
   input  logic                        req_cand_p2p_ok,
   input  logic [23:0]                 req_cand_bw_h2d,
   input  logic [23:0]                 req_cand_bw_d2h,
   input  logic [47:0]                 req_src_offset,
   input  logic [47:0]                 req_dst_offset,
   input  logic [35:0]                 req_range_bytes,
   input  logic                        dir_d2h,
   input  logic                        q_full,
   output logic                        q_push,
   output wcpd_pkg::item_type          q_data
);
   import wcpd_pkg::*;

   logic keep;

   // Drop transactions that give no result: unknown functions and empty ranges.
   always_comb begin
      case (req_func)
         FUNC_START: keep = 1'b1;
         FUNC_CAND:  keep = 1'b1;
         FUNC_RANGE: keep = (req_range_bytes != '0);
         default:    keep = 1'b0;
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full && keep;

   // Pick the bandwidth for the transfer direction; device to host falls back.
   always_comb begin
      q_data.func        = req_func;
      q_data.chunk_count = req_plan_chunk_count;
      q_data.is_direct   = req_cand_is_direct;
      q_data.p2p_ok      = req_cand_p2p_ok;
      q_data.bw          = (dir_d2h && req_cand_bw_d2h != '0) ? req_cand_bw_d2h
                                                               : req_cand_bw_h2d;
      q_data.src         = req_src_offset;
      q_data.dst         = req_dst_offset;
      q_data.range_bytes = req_range_bytes;
   end

endmodule

// ===== rtl/wcpd_back.sv =====
module wcpd_back #(
   parameter int unsigned MAX_PATHS            = 8,
   parameter int unsigned MAX_CHUNKS_PER_RANGE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  wcpd_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  wcpd_pkg::item_type q_data,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output wcpd_pkg::rsp_type  rsp
);
   import wcpd_pkg::*;

   localparam int unsigned IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
   localparam int unsigned PC_W  = $clog2(MAX_PATHS + 1);
   localparam int unsigned MC_W  = $clog2(MAX_CHUNKS_PER_RANGE + 1);
   localparam int unsigned LIM_W = CS_W + MC_W;
   localparam int unsigned PP_W  = 2 * BW_W;
   localparam int unsigned PR_W  = SCORE_W + BW_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_LOAD = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_CMP  = 7'b0010000,
      S_EMIT = 7'b0100000,
      S_WAIT = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   item_type             cur_ff, cur_in;
   logic [PC_W-1:0]      count_ff, count_in;
   logic [BW_W-1:0]      direct_bw_ff, direct_bw_in;
   logic [1:0]           mode_ff, mode_in;
   logic [BW_W-1:0]      bw_arr_ff [MAX_PATHS];
   logic [BW_W-1:0]      bw_arr_in [MAX_PATHS];
   logic [SCORE_W-1:0]   score_arr_ff [MAX_PATHS];
   logic [SCORE_W-1:0]   score_arr_in [MAX_PATHS];
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [SCORE_W-1:0]   best_score_ff, best_score_in;
   logic [BW_W-1:0]      best_bw_ff, best_bw_in;
   logic [RB_W-1:0]      done_ff, done_in;
   logic [PP_W-1:0]      a_hi_ff, a_hi_in, a_lo_ff, a_lo_in;
   logic [PP_W-1:0]      b_hi_ff, b_hi_in, b_lo_ff, b_lo_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic                 emit_ok, emit;
   rsp_type              emit_data;
   logic [SCORE_W-1:0]   rd_score;
   logic [BW_W-1:0]      rd_bw;
   logic [CS_W-1:0]      cs_eff;
   logic [LIM_W-1:0]     range_limit;
   logic [RB_W-1:0]      rem;
   logic [CS_W-1:0]      len;
   logic                 last_chunk;
   logic [SCORE_W:0]     score_sum;
   logic [PR_W-1:0]      prod_a, prod_b;
   logic [39:0]          ratio_lhs, ratio_rhs;
   logic                 relay_bad;
   logic [1:0]           start_mode;
   logic [PC_W-1:0]      idx_next;

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;
   assign emit_ok   = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;

   // Single read port of the path table, addressed by the scan index.
   assign rd_score = score_arr_ff[idx_ff];
   assign rd_bw    = bw_arr_ff[idx_ff];

   // Chunk geometry; a range needs too many chunks when it exceeds the limit times the size.
   assign cs_eff      = (cfg.chunk_size == '0) ? CS_W'(1) : cfg.chunk_size;
   assign range_limit = LIM_W'(cs_eff) * LIM_W'(MAX_CHUNKS_PER_RANGE);
   assign rem         = cur_ff.range_bytes - done_ff;
   assign last_chunk  = (rem <= RB_W'(cs_eff));
   assign len         = last_chunk ? rem[CS_W-1:0] : cs_eff;
   assign score_sum   = (SCORE_W+1)'(best_score_ff) + (SCORE_W+1)'(len);

   // Cross products of the ratio test, rebuilt from registered partial products.
   assign prod_a   = {a_hi_ff, {BW_W{1'b0}}} + PR_W'(a_lo_ff);
   assign prod_b   = {b_hi_ff, {BW_W{1'b0}}} + PR_W'(b_lo_ff);
   assign idx_next = PC_W'(idx_ff) + PC_W'(1);

   // Relay admission.
   assign ratio_lhs = 40'({cur_ff.bw, 8'd0});
   assign ratio_rhs = 40'(direct_bw_ff) * 40'(cfg.ratio_floor);
   assign relay_bad = (mode_ff == MODE_DIRECT) || !cur_ff.p2p_ok || (cur_ff.bw == '0) ||
                      (cur_ff.bw < cfg.bw_floor) ||
                      (direct_bw_ff != '0 && cfg.ratio_floor != '0 && ratio_lhs < ratio_rhs);

   // Mode fixed by a start transaction, with the fallback to direct only.
   always_comb begin
      start_mode = (cfg.mode == MODE_ALIAS) ? MODE_POOL : cfg.mode;
      if (start_mode == MODE_POOL && cur_ff.chunk_count < cfg.min_chunks) begin
         start_mode = MODE_DIRECT;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      direct_bw_in  = direct_bw_ff;
      mode_in       = mode_ff;
      bw_arr_in     = bw_arr_ff;
      score_arr_in  = score_arr_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_score_in = best_score_ff;
      best_bw_in    = best_bw_ff;
      done_in       = done_ff;
      a_hi_in       = a_hi_ff;
      a_lo_in       = a_lo_ff;
      b_hi_in       = b_hi_ff;
      b_lo_in       = b_lo_ff;
      emit          = 1'b0;
      emit_data     = '0;
      emit_data.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               cur_in   = q_data;
               done_in  = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (emit_ok) begin
               state_in = S_IDLE;
               case (cur_ff.func)
                  FUNC_START: begin
                     mode_in      = start_mode;
                     count_in     = '0;
                     direct_bw_in = '0;
                     for (int i = 0; i < MAX_PATHS; i++) begin
                        score_arr_in[i] = '0;
                     end
                     emit             = 1'b1;
                     emit_data.status = ST_STARTED;
                  end
                  FUNC_CAND: begin
                     emit = 1'b1;
                     if (cur_ff.is_direct) begin
                        if (count_ff != '0) begin
                           emit_data.status = ST_REJECTED;
                        end else begin
                           direct_bw_in = cur_ff.bw;
                           if (mode_ff == MODE_RELAY || cur_ff.bw == '0) begin
                              emit_data.status = ST_REJECTED;
                           end else begin
                              bw_arr_in[0]     = cur_ff.bw;
                              score_arr_in[0]  = '0;
                              count_in         = PC_W'(1);
                              emit_data.status = ST_ACCEPTED;
                           end
                        end
                     end else if (relay_bad) begin
                        emit_data.status = ST_REJECTED;
                     end else if (count_ff >= PC_W'(MAX_PATHS)) begin
                        emit_data.status = ST_FULL;
                     end else begin
                        bw_arr_in[count_ff[IDX_W-1:0]]    = cur_ff.bw;
                        score_arr_in[count_ff[IDX_W-1:0]] = '0;
                        count_in             = count_ff + PC_W'(1);
                        emit_data.status     = ST_ACCEPTED;
                        emit_data.path_index = PI_W'(count_ff);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        emit             = 1'b1;
                        emit_data.status = ST_NO_PATH;
                     end else if ((LIM_W+RB_W)'(cur_ff.range_bytes) >
                                  (LIM_W+RB_W)'(range_limit)) begin
                        emit             = 1'b1;
                        emit_data.status = ST_TOO_LONG;
                     end else begin
                        idx_in   = '0;
                        state_in = S_LOAD;
                     end
                  end
               endcase
            end
         end
         // Path zero starts each scan as the best so far.
         S_LOAD: begin
            best_in       = idx_ff;
            best_score_in = rd_score;
            best_bw_in    = rd_bw;
            if (count_ff == PC_W'(1)) begin
               state_in = S_EMIT;
            end else begin
               idx_in   = IDX_W'(1);
               state_in = S_MUL;
            end
         end
         // Partial products of score times bandwidth, 24 bits at a time.
         S_MUL: begin
            a_hi_in  = rd_score[SCORE_W-1:BW_W] * best_bw_ff;
            a_lo_in  = rd_score[BW_W-1:0] * best_bw_ff;
            b_hi_in  = best_score_ff[SCORE_W-1:BW_W] * rd_bw;
            b_lo_in  = best_score_ff[BW_W-1:0] * rd_bw;
            state_in = S_CMP;
         end
         // A strictly smaller load ratio takes over, so the lower index wins ties.
         S_CMP: begin
            if (prod_a < prod_b) begin
               best_in       = idx_ff;
               best_score_in = rd_score;
               best_bw_in    = rd_bw;
            end
            if (idx_next == count_ff) begin
               state_in = S_EMIT;
            end else begin
               idx_in   = idx_next[IDX_W-1:0];
               state_in = S_MUL;
            end
         end
         // Charge the chunk to the chosen path and send it out.
         S_EMIT: begin
            if (emit_ok) begin
               score_arr_in[best_ff] = score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
               emit                 = 1'b1;
               emit_data.status     = ST_CHUNK;
               emit_data.path_index = PI_W'(best_ff);
               emit_data.src        = cur_ff.src + OFS_W'(done_ff);
               emit_data.dst        = cur_ff.dst + OFS_W'(done_ff);
               emit_data.len        = len;
               emit_data.last       = last_chunk;
               done_in              = done_ff + RB_W'(len);
               idx_in               = '0;
               state_in             = last_chunk ? S_WAIT : S_LOAD;
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = emit_data;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         direct_bw_ff <= '0;
         mode_ff      <= MODE_POOL;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PATHS; i++) begin
            score_arr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         direct_bw_ff <= direct_bw_in;
         mode_ff      <= mode_in;
         out_valid_ff <= out_valid_in;
         score_arr_ff <= score_arr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      bw_arr_ff     <= bw_arr_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_score_ff <= best_score_in;
      best_bw_ff    <= best_bw_in;
      done_ff       <= done_in;
      a_hi_ff       <= a_hi_in;
      a_lo_ff       <= a_lo_in;
      b_hi_ff       <= b_hi_in;
      b_lo_ff       <= b_lo_in;
      out_ff        <= out_in;
   end

endmodule

// ===== rtl/weighted_chunk_path_dispatcher_top.sv =====
// Plans a transfer over up to MAX_PATHS paths. A start transaction clears the path table
// and fixes the mode, candidate transactions admit the direct path and relay paths, and
// each range transaction is cut into chunks that go to the path with the least bytes per
// unit of bandwidth. For each chunk the sequencer scans the path table through one shared
// cross-multiply unit. A two-entry queue between the front end and the sequencer lets new
// transactions arrive while a range is worked on, and a result register lets work go on
// while the last result waits to be popped.
module weighted_chunk_path_dispatcher_top #(
   parameter int unsigned MAX_PATHS            = 8,
   parameter int unsigned MAX_CHUNKS_PER_RANGE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [19:0] req_plan_chunk_count,
   input  logic        req_cand_is_direct,
   input  logic        req_cand_p2p_ok,
   input  logic [23:0] req_cand_bw_h2d,
   input  logic [23:0] req_cand_bw_d2h,
   input  logic [47:0] req_src_offset,
   input  logic [47:0] req_dst_offset,
   input  logic [35:0] req_range_bytes,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_path_index,
   output logic [47:0] rsp_chunk_src,
   output logic [47:0] rsp_chunk_dst,
   output logic [30:0] rsp_chunk_len,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wcpd_pkg::*;

   logic [CS_W-1:0]    chunk_size_ff;
   logic [1:0]         mode_ff;
   logic [CNT_W-1:0]   min_chunks_ff;
   logic [BW_W-1:0]    bw_floor_ff;
   logic [RATIO_W-1:0] ratio_floor_ff;
   logic               dir_d2h_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;
   cfg_type            cfg;
   item_type           fq_data, qb_data;
   logic               fq_push, q_full, q_empty, q_pop;
   rsp_type            rsp;

   // Register file on the control port.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff  <= CS_W'(1048576);
         mode_ff        <= MODE_POOL;
         min_chunks_ff  <= '0;
         bw_floor_ff    <= '0;
         ratio_floor_ff <= '0;
         dir_d2h_ff     <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CHUNK_SIZE:  chunk_size_ff  <= csr_pwdata[CS_W-1:0];
            REG_MODE:        mode_ff        <= csr_pwdata[1:0];
            REG_MIN_CHUNKS:  min_chunks_ff  <= csr_pwdata[CNT_W-1:0];
            REG_BW_FLOOR:    bw_floor_ff    <= csr_pwdata[BW_W-1:0];
            REG_RATIO_FLOOR: ratio_floor_ff <= csr_pwdata[RATIO_W-1:0];
            REG_DIR_D2H:     dir_d2h_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (csr_idx)
         REG_CHUNK_SIZE:  csr_prdata = 32'(chunk_size_ff);
         REG_MODE:        csr_prdata = 32'(mode_ff);
         REG_MIN_CHUNKS:  csr_prdata = 32'(min_chunks_ff);
         REG_BW_FLOOR:    csr_prdata = 32'(bw_floor_ff);
         REG_RATIO_FLOOR: csr_prdata = 32'(ratio_floor_ff);
         REG_DIR_D2H:     csr_prdata = 32'(dir_d2h_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.chunk_size  = chunk_size_ff;
      cfg.mode        = mode_ff;
      cfg.min_chunks  = min_chunks_ff;
      cfg.bw_floor    = bw_floor_ff;
      cfg.ratio_floor = ratio_floor_ff;
   end

   wcpd_front u_front (
      .req_push             (req_push),
      .req_full             (req_full),
      .req_func             (req_func),
      .req_plan_chunk_count (req_plan_chunk_count),
      .req_cand_is_direct   (req_cand_is_direct),
      .req_cand_p2p_ok      (req_cand_p2p_ok),
      .req_cand_bw_h2d      (req_cand_bw_h2d),
      .req_cand_bw_d2h      (req_cand_bw_d2h),
      .req_src_offset       (req_src_offset),
      .req_dst_offset       (req_dst_offset),
      .req_range_bytes      (req_range_bytes),
      .dir_d2h              (dir_d2h_ff),
      .q_full               (q_full),
      .q_push               (fq_push),
      .q_data               (fq_data)
   );

   wcpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (qb_data)
   );

   wcpd_back #(
      .MAX_PATHS            (MAX_PATHS),
      .MAX_CHUNKS_PER_RANGE (MAX_CHUNKS_PER_RANGE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_data    (qb_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_path_index = rsp.path_index;
   assign rsp_chunk_src  = rsp.src;
   assign rsp_chunk_dst  = rsp.dst;
   assign rsp_chunk_len  = rsp.len;
   assign rsp_last       = rsp.last;

endmodule

// ===== rtl/wcpd_checker.sv =====
module wcpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_path_index,
   input logic [30:0] rsp_chunk_len,
   input logic        rsp_last
);
   import wcpd_pkg::*;

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // A waiting result that is not taken stays in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_status) &&
                                    $stable(rsp_chunk_len)))
      else $error("waiting result changed");

   // Single-result statuses close their transaction and name no path.
   a_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_CHUNK && rsp_status != ST_ACCEPTED)
         |-> (rsp_last && rsp_path_index == 3'd0 && rsp_chunk_len == '0))
      else $error("malformed status result");

   // Every chunk carries bytes.
   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_CHUNK) |-> (rsp_chunk_len != '0))
      else $error("empty chunk");

endmodule

bind weighted_chunk_path_dispatcher_top wcpd_checker u_wcpd_checker (.*);

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wcpd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_func;
   logic [19:0] req_plan_chunk_count;
   logic        req_cand_is_direct;
   logic        req_cand_p2p_ok;
   logic [23:0] req_cand_bw_h2d;
   logic [23:0] req_cand_bw_d2h;
   logic [47:0] req_src_offset;
   logic [47:0] req_dst_offset;
   logic [35:0] req_range_bytes;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_path_index;
   logic [47:0] rsp_chunk_src;
   logic [47:0] rsp_chunk_dst;
   logic [30:0] rsp_chunk_len;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   localparam int NPATH = 8;
   localparam int NCHUNK = 64;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   weighted_chunk_path_dispatcher_top dut (.*);

   // Planner state as seen from outside.
   logic [30:0] cfg_chunk_size;
   logic [1:0]  cfg_mode;
   logic [19:0] cfg_min_chunks;
   logic [23:0] cfg_bw_floor;
   logic [15:0] cfg_ratio_floor;
   logic        cfg_d2h;
   logic [23:0] bw_table [NPATH];
   logic [47:0] score_table [NPATH];
   int          table_count;
   logic [23:0] direct_bw_m;
   logic [1:0]  plan_mode;

   rsp_type     pending_rsp[$];
   int          mismatch_count;
   int          sent_burst;
   bit          stall_phase;

   // Record one expected result transaction.
   task automatic push_rsp(logic [2:0] st, logic [2:0] idx, logic [47:0] s, logic [47:0] d,
                           logic [30:0] l, logic lst);
      rsp_type r;
      r.status = st;
      r.path_index = idx;
      r.src = s;
      r.dst = d;
      r.len = l;
      r.last = lst;
      pending_rsp.insert(pending_rsp.size(), r);
   endtask

   // Work out the results of one input transaction and update the planner state.
   task automatic plan_item(logic [1:0] fn, logic [19:0] cnt, logic isd, logic p2p,
                            logic [23:0] h2d, logic [23:0] d2h, logic [47:0] src,
                            logic [47:0] dst, logic [35:0] rb);
      logic [1:0]  m;
      logic [23:0] bw;
      logic [31:0] cs;
      logic [36:0] n;
      logic [36:0] done;
      logic [36:0] len;
      logic [72:0] lhs;
      logic [72:0] rhs;
      int          best;
      if (fn == FUNC_START) begin
         m = cfg_mode;
         if (m == MODE_ALIAS) m = MODE_POOL;
         if (m == MODE_POOL && cnt < cfg_min_chunks) m = MODE_DIRECT;
         plan_mode = m;
         table_count = 0;
         direct_bw_m = '0;
         for (int i = 0; i < NPATH; i++) score_table[i] = '0;
         push_rsp(ST_STARTED, 0, 0, 0, 0, 1);
      end else if (fn == FUNC_CAND) begin
         bw = (cfg_d2h && d2h != 0) ? d2h : h2d;
         if (isd) begin
            if (table_count != 0) begin
               push_rsp(ST_REJECTED, 0, 0, 0, 0, 1);
            end else begin
               direct_bw_m = bw;
               if (plan_mode == MODE_RELAY || bw == 0) begin
                  push_rsp(ST_REJECTED, 0, 0, 0, 0, 1);
               end else begin
                  bw_table[0] = bw;
                  score_table[0] = '0;
                  table_count = 1;
                  push_rsp(ST_ACCEPTED, 0, 0, 0, 0, 1);
               end
            end
         end else if (plan_mode == MODE_DIRECT || !p2p || bw == 0 || bw < cfg_bw_floor ||
                      (direct_bw_m != 0 && cfg_ratio_floor != 0 &&
                       {bw, 8'd0} < 48'(direct_bw_m) * cfg_ratio_floor)) begin
            push_rsp(ST_REJECTED, 0, 0, 0, 0, 1);
         end else if (table_count >= NPATH) begin
            push_rsp(ST_FULL, 0, 0, 0, 0, 1);
         end else begin
            bw_table[table_count] = bw;
            score_table[table_count] = '0;
            push_rsp(ST_ACCEPTED, 3'(table_count), 0, 0, 0, 1);
            table_count++;
         end
      end else if (fn == FUNC_RANGE && rb != 0) begin
         cs = (cfg_chunk_size == 0) ? 32'd1 : 32'(cfg_chunk_size);
         if (table_count == 0) begin
            push_rsp(ST_NO_PATH, 0, 0, 0, 0, 1);
         end else begin
            n = (37'(rb) + cs - 1) / cs;
            if (n > NCHUNK) begin
               push_rsp(ST_TOO_LONG, 0, 0, 0, 0, 1);
            end else begin
               done = '0;
               for (int k = 0; k < n; k++) begin
                  len = 37'(rb) - done;
                  if (len > cs) len = cs;
                  best = 0;
                  for (int i = 1; i < table_count; i++) begin
                     lhs = 73'(score_table[i]) * bw_table[best];
                     rhs = 73'(score_table[best]) * bw_table[i];
                     if (lhs < rhs) best = i;
                  end
                  if (49'(score_table[best]) + len > 49'(MAX48)) score_table[best] = MAX48;
                  else score_table[best] = score_table[best] + 48'(len);
                  push_rsp(ST_CHUNK, 3'(best), src + 48'(done), dst + 48'(done), 31'(len),
                           k + 1 == n);
                  done = done + len;
               end
            end
         end
      end
   endtask

   // Clock generation.
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #200ms;
      $display("tb: FAIL");
      $finish;
   end

   // Receiver with its own stall pattern; every popped result is checked.
   initial begin
      rsp_type exp_r;
      rsp_pop = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("tb: unexpected result status %0d", rsp_status);
            end else begin
               exp_r = pending_rsp.pop_front();
               if (rsp_status !== exp_r.status || rsp_path_index !== exp_r.path_index ||
                   rsp_chunk_src !== exp_r.src || rsp_chunk_dst !== exp_r.dst ||
                   rsp_chunk_len !== exp_r.len || rsp_last !== exp_r.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("tb: mismatch exp st=%0d pi=%0d s=%h d=%h l=%0d last=%0d",
                              exp_r.status, exp_r.path_index, exp_r.src, exp_r.dst,
                              exp_r.len, exp_r.last);
                     $display("tb:          got st=%0d pi=%0d s=%h d=%h l=%0d last=%0d",
                              rsp_status, rsp_path_index, rsp_chunk_src, rsp_chunk_dst,
                              rsp_chunk_len, rsp_last);
                  end
               end
            end
         end
         @(negedge clock);
         if (stall_phase) rsp_pop <= ($urandom_range(0, 3) != 0);
         else rsp_pop <= 1;
         if ($urandom_range(0, 40) == 0) stall_phase = ~stall_phase;
      end
   end

   // Send one input transaction, with bursts and random gaps in between.
   task automatic send_item(logic [1:0] fn, logic [19:0] cnt, logic isd, logic p2p,
                            logic [23:0] h2d, logic [23:0] d2h, logic [47:0] src,
                            logic [47:0] dst, logic [35:0] rb);
      int gap;
      if (sent_burst == 0) begin
         sent_burst = $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_push <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      sent_burst--;
      req_push <= 1;
      req_func <= fn;
      req_plan_chunk_count <= cnt;
      req_cand_is_direct <= isd;
      req_cand_p2p_ok <= p2p;
      req_cand_bw_h2d <= h2d;
      req_cand_bw_d2h <= d2h;
      req_src_offset <= src;
      req_dst_offset <= dst;
      req_range_bytes <= rb;
      do @(posedge clock); while (req_full);
      plan_item(fn, cnt, isd, p2p, h2d, d2h, src, dst, rb);
      @(negedge clock);
   endtask

   // Register write over the control port, only while idle.
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_CHUNK_SIZE:  cfg_chunk_size = val[30:0];
         REG_MODE:        cfg_mode = val[1:0];
         REG_MIN_CHUNKS:  cfg_min_chunks = val[19:0];
         REG_BW_FLOOR:    cfg_bw_floor = val[23:0];
         REG_RATIO_FLOOR: cfg_ratio_floor = val[15:0];
         REG_DIR_D2H:     cfg_d2h = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait until every expected result has arrived, then let the pipeline drain.
   task automatic drain;
      req_push <= 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic set_config(logic [30:0] cs, logic [1:0] m, logic [19:0] mc,
                             logic [23:0] bf, logic [15:0] rf, logic d);
      drain();
      write_reg(REG_CHUNK_SIZE, cs);
      write_reg(REG_MODE, m);
      write_reg(REG_MIN_CHUNKS, mc);
      write_reg(REG_BW_FLOOR, bf);
      write_reg(REG_RATIO_FLOOR, rf);
      write_reg(REG_DIR_D2H, d);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_start(logic [19:0] cnt);
      send_item(FUNC_START, cnt, 0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic send_cand(logic isd, logic p2p, logic [23:0] h2d, logic [23:0] d2h);
      send_item(FUNC_CAND, 0, isd, p2p, h2d, d2h, 0, 0, 0);
   endtask

   task automatic send_range(logic [47:0] s, logic [47:0] d, logic [35:0] rb);
      send_item(FUNC_RANGE, 0, 0, 0, 0, 0, s, d, rb);
   endtask

   function automatic logic [23:0] rand_bw();
      case ($urandom_range(0, 4))
         0: return 24'(0);
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1, 16));
         default: return 24'($urandom);
      endcase
   endfunction

   // Directed: extremes, every function, empty table, full table, fallbacks, wraps.
   task automatic test_directed;
      send_range(0, 0, 100);
      send_range(MAX48, MAX48, 0);
      send_item(2'd3, 20'hFFFFF, 1, 1, 24'hFFFFFF, 24'hFFFFFF, MAX48, MAX48, 36'hF_FFFF_FFFF);
      send_start(20'hFFFFF);
      send_cand(0, 1, 24'd100, 0);
      send_cand(1, 0, 24'hFFFFFF, 24'd5);
      send_cand(1, 1, 24'd1, 0);
      send_cand(0, 0, 24'd50, 0);
      send_cand(0, 1, 0, 24'hFFFFFF);
      for (int i = 0; i < 8; i++) send_cand(0, 1, 24'(i + 1) * 3, 0);
      send_range(MAX48 - 5, 48'd7, 36'd5000000);
      send_range(0, 0, 36'hF_FFFF_FFFF);
      send_range(48'h1234, MAX48, 36'd64 * 36'd1048576);
      set_config(31'd0, MODE_DIRECT, 20'd0, 0, 0, 1);
      send_start(0);
      send_cand(1, 1, 24'd9, 24'd0);
      send_cand(0, 1, 24'd9, 24'd9);
      send_range(0, 0, 36'd64);
      send_range(0, 0, 36'd65);
      set_config(31'h4000_0000, MODE_ALIAS, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF, 0);
      send_start(20'hFFFFE);
      send_cand(1, 1, 24'd1, 0);
      send_range(MAX48, 0, 36'hF_FFFF_FFFF);
   endtask

   // Random plans: mostly well-formed start, candidates, ranges.
   task automatic test_random_plans(int items);
      int          sent;
      logic [35:0] rb;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 3) == 0)
            set_config(31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4096)),
                       2'($urandom_range(0, 3)), 20'($urandom_range(0, 40)),
                       $urandom_range(0, 1) ? 24'(0) : 24'($urandom_range(0, 64)),
                       $urandom_range(0, 1) ? 16'(0) : 16'($urandom),
                       1'($urandom_range(0, 1)));
         send_start(20'($urandom));
         sent++;
         if ($urandom_range(0, 5) != 0) begin
            send_cand(1, 1'($urandom), rand_bw(), rand_bw());
            sent++;
         end
         repeat ($urandom_range(0, 10)) begin
            send_cand(1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 5) != 0),
                      rand_bw(), rand_bw());
            sent++;
         end
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
               0: rb = 36'($urandom) << 4 | 36'($urandom_range(0, 15));
               1: rb = 36'(0);
               default: rb = 36'(cfg_chunk_size == 0 ? 1 : cfg_chunk_size) *
                             36'($urandom_range(0, 66)) + 36'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 9) == 0) rb = 36'hF_FFFF_FFFF;
            if ($urandom_range(0, 15) == 0)
               send_item(2'd3, 20'($urandom), 1'($urandom), 1'($urandom), 24'($urandom),
                         24'($urandom), {16'($urandom), 32'($urandom)},
                         {16'($urandom), 32'($urandom)}, rb);
            else
               send_range({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)}, rb);
            sent++;
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      req_push = 0;
      req_func = '0;
      req_plan_chunk_count = '0;
      req_cand_is_direct = 0;
      req_cand_p2p_ok = 0;
      req_cand_bw_h2d = '0;
      req_cand_bw_d2h = '0;
      req_src_offset = '0;
      req_dst_offset = '0;
      req_range_bytes = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_chunk_size = 31'd1048576;
      cfg_mode = MODE_POOL;
      cfg_min_chunks = '0;
      cfg_bw_floor = '0;
      cfg_ratio_floor = '0;
      cfg_d2h = 0;
      table_count = 0;
      direct_bw_m = '0;
      plan_mode = MODE_POOL;
      for (int i = 0; i < NPATH; i++) score_table[i] = '0;
      mismatch_count = 0;
      sent_burst = 0;
      stall_phase = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_random_plans(290);
      drain();
      if (mismatch_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wcpd_pkg.sv
rtl/wcpd_queue.sv
rtl/wcpd_front.sv
rtl/wcpd_back.sv
rtl/weighted_chunk_path_dispatcher_top.sv
rtl/wcpd_checker.sv
test/tb.sv
